FILE: hw/rtl/rma_pkg.sv
// ----------------------------------------------------------------------------
// rma_pkg
// Shared widths, codes and helpers for the ring moving-average block.
// ----------------------------------------------------------------------------
package rma_pkg;

  localparam int unsigned MaxWindow = 256;
  localparam int unsigned RingAw    = $clog2(MaxWindow);
  localparam int unsigned DataW     = 32;
  localparam int unsigned SumW      = 40;
  localparam int unsigned LevelW    = 9;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned SwW       = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DivCntW   = $clog2(SumW);

  // request modes
  localparam logic [ModeW-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_RESTART = 2'd1;
  localparam logic [ModeW-1:0] MODE_LEVEL   = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STORAGE  = 2'd1;

  // storage width codes (anything else is 32 bits)
  localparam logic [SwW-1:0] SW_8  = 2'd0;
  localparam logic [SwW-1:0] SW_16 = 2'd1;
  localparam logic [SwW-1:0] SW_32 = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [DataW-1:0] cut_to_storage(input logic [DataW-1:0] v,
                                                       input logic [SwW-1:0]   sw);
    logic [DataW-1:0] r;
    case (sw)
      SW_8:    r = {{(DataW-8){v[7]}}, v[7:0]};
      SW_16:   r = {{(DataW-16){v[15]}}, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [LevelW-1:0] eff_capacity(input logic [LevelW-1:0] cap);
    logic [LevelW-1:0] r;
    if (cap == '0) begin
      r = LevelW'(1);
    end else if (cap > LevelW'(MaxWindow)) begin
      r = LevelW'(MaxWindow);
    end else begin
      r = cap;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rma_div.sv
// ----------------------------------------------------------------------------
// rma_div
// Restoring divider: signed window sum over unsigned level, one bit a cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rma_div import rma_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SumW-1:0]   dividend_i,
  input  logic [LevelW-1:0]        divisor_i,
  output logic signed [DataW-1:0]  quotient_o,
  output div_stat_t                status_o
);

  logic [SumW-1:0]    quo_q, quo_d;
  logic [LevelW-1:0]  rem_q, rem_d;
  logic [LevelW-1:0]  div_q, div_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [LevelW:0]    rem_sh;
  logic               ge;

  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      neg_d  = dividend_i[SumW-1];
      quo_d  = dividend_i[SumW-1] ? SumW'(-dividend_i) : dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = DivCntW'(SumW - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = ge ? LevelW'(rem_sh - {1'b0, div_q}) : rem_sh[LevelW-1:0];
      quo_d = {quo_q[SumW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  // average of 32-bit values always fits in 32 bits
  assign quotient_o = neg_q ? DataW'(-quo_q[DataW-1:0]) : quo_q[DataW-1:0];
  assign status_o   = '{busy: busy_q, done: done_q};

endmodule

FILE: hw/rtl/ring_moving_average.sv
// ----------------------------------------------------------------------------
// ring_moving_average
// Running average over a ring of the last `level` samples, kept in one
// 256 x 32 synchronous RAM, with an iterative divide by the level.
// ----------------------------------------------------------------------------
// A sample request reads the oldest entry, swaps it for the new one in sum and RAM,
//   runs a 40-step divide, then loads the output register; input stalls all along.
// The first sample after reset, restart or register write first fills all `level`
//   entries with its value; a change-level request refills from entry 0, no result.
// The restoring divider gives one quotient bit a cycle over the 40-bit sum.
// Reset: level 256, 32-bit storage, sum and write position zero, window not filled;
//   RAM contents are left as they are (every entry is refilled before use).
module ring_moving_average import rma_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [LevelW-1:0]        cfg_wdata_i,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ModeW-1:0]         mode_i,
  input  logic signed [DataW-1:0]  sample_i,
  input  logic [LevelW-1:0]        new_level_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DataW-1:0]  average_o
);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,  // accept a request
    ST_RD0  = 6'b000010,  // entry 0 arriving from RAM for a shrink refill
    ST_FILL = 6'b000100,  // write the fill value over the whole window
    ST_READ = 6'b001000,  // read the oldest entry at the write position
    ST_UPD  = 6'b010000,  // swap oldest for newest in sum and RAM, start divide
    ST_DIV  = 6'b100000   // wait for quotient, load output register
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [LevelW-1:0] cap_q, cap_d;
  logic [SwW-1:0]    sw_q, sw_d;

  // window state
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [RingAw-1:0]      wpos_q, wpos_d;
  logic [LevelW-1:0]      level_q, level_d;
  logic                   filled_q, filled_d;

  // work registers
  logic [DataW-1:0]  stored_q, stored_d;     // cut sample of the current request
  logic [DataW-1:0]  fill_val_q, fill_val_d;
  logic [RingAw-1:0] fill_cnt_q, fill_cnt_d;
  logic              smp_pend_q, smp_pend_d; // a sample follows the refill

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  average_q, average_d;

  // RAM
  logic [DataW-1:0]  ring_mem [MaxWindow];
  logic [DataW-1:0]  rdata_q;
  logic [RingAw-1:0] raddr;
  logic [RingAw-1:0] waddr;
  logic [DataW-1:0]  wdata;
  logic              we;

  // divider
  logic                   div_start;
  logic signed [SumW-1:0] div_dividend;
  logic [DataW-1:0]       div_quot;
  div_stat_t              div_stat;

  logic             accept;
  logic             out_take;
  logic [LevelW-1:0] level_m1;
  logic [LevelW-1:0] wpos_inc;
  logic             level_ok;
  logic [DataW-1:0] cut_sample;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_take   = out_valid_q && !out_stall_i;
  assign level_m1   = level_q - 1'b1;
  assign wpos_inc   = {1'b0, wpos_q} + 1'b1;
  assign cut_sample = cut_to_storage(sample_i, sw_q);
  // shrink only, once the window holds data
  assign level_ok   = filled_q && (new_level_i != level_q) && (new_level_i != '0) &&
                      (new_level_i <= level_q);

  // Only entry 0 (shrink refill) or the write position is ever read. A write
  // always lands before the read of the same entry is registered, so no
  // forwarding path is needed.
  assign raddr = (state_q == ST_READ) ? wpos_q : '0;

  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    sw_d         = sw_q;
    sum_d        = sum_q;
    wpos_d       = wpos_q;
    level_d      = level_q;
    filled_d     = filled_q;
    stored_d     = stored_q;
    fill_val_d   = fill_val_q;
    fill_cnt_d   = fill_cnt_q;
    smp_pend_d   = smp_pend_q;
    out_valid_d  = out_valid_q;
    average_d    = average_q;
    we           = 1'b0;
    waddr        = wpos_q;
    wdata        = stored_q;
    div_start    = 1'b0;
    div_dividend = sum_q;

    if (out_take) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_SAMPLE: begin
              stored_d   = cut_sample;
              fill_val_d = cut_sample;
              if (!filled_q) begin
                // first sample: whole window takes this value
                sum_d      = '0;
                fill_cnt_d = '0;
                smp_pend_d = 1'b1;
                state_d    = ST_FILL;
              end else begin
                state_d = ST_READ;
              end
            end
            MODE_RESTART: begin
              filled_d = 1'b0;
            end
            MODE_LEVEL: begin
              if (level_ok) begin
                level_d    = new_level_i;
                smp_pend_d = 1'b0;
                state_d    = ST_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD0: begin
        fill_val_d = rdata_q;
        sum_d      = '0;
        fill_cnt_d = '0;
        state_d    = ST_FILL;
      end
      ST_FILL: begin
        we         = 1'b1;
        waddr      = fill_cnt_q;
        wdata      = fill_val_q;
        sum_d      = sum_q + SumW'(signed'(fill_val_q));
        fill_cnt_d = fill_cnt_q + 1'b1;
        if (fill_cnt_q == level_m1[RingAw-1:0]) begin
          wpos_d   = '0;
          filled_d = 1'b1;
          state_d  = smp_pend_q ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // oldest leaves, newest enters
        sum_d        = sum_q - SumW'(signed'(rdata_q)) + SumW'(signed'(stored_q));
        we           = 1'b1;
        waddr        = wpos_q;
        wdata        = stored_q;
        div_start    = 1'b1;
        div_dividend = sum_d;
        wpos_d       = (wpos_inc >= level_q) ? '0 : wpos_inc[RingAw-1:0];
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done && (!out_valid_q || out_take)) begin
          out_valid_d = 1'b1;
          average_d   = div_quot;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write reinitialises the window
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAPACITY: begin
          cap_d    = cfg_wdata_i;
          level_d  = eff_capacity(cfg_wdata_i);
          sum_d    = '0;
          wpos_d   = '0;
          filled_d = 1'b0;
          state_d  = ST_IDLE;
        end
        REG_STORAGE: begin
          sw_d     = cfg_wdata_i[SwW-1:0];
          level_d  = eff_capacity(cap_q);
          sum_d    = '0;
          wpos_d   = '0;
          filled_d = 1'b0;
          state_d  = ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= LevelW'(MaxWindow);
      sw_q        <= SW_32;
      sum_q       <= '0;
      wpos_q      <= '0;
      level_q     <= LevelW'(MaxWindow);
      filled_q    <= 1'b0;
      fill_cnt_q  <= '0;
      smp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      sw_q        <= sw_d;
      sum_q       <= sum_d;
      wpos_q      <= wpos_d;
      level_q     <= level_d;
      filled_q    <= filled_d;
      fill_cnt_q  <= fill_cnt_d;
      smp_pend_q  <= smp_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stored_q   <= stored_d;
    fill_val_q <= fill_val_d;
    average_q  <= average_d;
  end

  // sample ring RAM, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      ring_mem[waddr] <= wdata;
    end
    rdata_q <= ring_mem[raddr];
  end

  rma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (level_q),
    .quotient_o (div_quot),
    .status_o   (div_stat)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

endmodule

FILE: hw/rtl/rma_checker.sv
// ----------------------------------------------------------------------------
// rma_port_props
// Port-level checks for the ring moving-average block.
// ----------------------------------------------------------------------------
module rma_port_props import rma_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [ModeW-1:0]  mode_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DataW-1:0]  average_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_o))
    else $error("stalled result changed");

  // a sample request keeps the block busy
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_SAMPLE) && !cfg_we_i |=> in_stall_o)
    else $error("no busy phase after sample request");

  // a restart request leaves the block ready for the next request
  a_restart_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_RESTART) |=> !in_stall_o)
    else $error("restart request left the block busy");

  // a result only appears at the end of a busy phase
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

endmodule

bind ring_moving_average rma_port_props u_rma_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .average_o   (average_o)
);

FILE: test/rma_checker.sv
// ----------------------------------------------------------------------------
// rma_checker
// Watches the register port and both channels of the moving-average block,
// keeps its own image of the window and compares every average it emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rma_checker import rma_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [LevelW-1:0]       cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [ModeW-1:0]        mode_i,
  input  logic signed [DataW-1:0] sample_i,
  input  logic [LevelW-1:0]       new_level_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [DataW-1:0] average_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  logic [LevelW-1:0]       capacity_reg;
  logic [SwW-1:0]          width_code;
  logic signed [DataW-1:0] window_store [MaxWindow];
  logic signed [SumW-1:0]  window_sum;
  logic [LevelW-1:0]       wr_pos;
  logic [LevelW-1:0]       level;
  logic                    primed;
  logic signed [DataW-1:0] averages_due [$];
  int unsigned             mismatches;

  function automatic logic signed [DataW-1:0] narrow(input logic [DataW-1:0] raw);
    case (width_code)
      SW_8:    return {{(DataW-8){raw[7]}}, raw[7:0]};
      SW_16:   return {{(DataW-16){raw[15]}}, raw[15:0]};
      default: return raw;
    endcase
  endfunction

  // register write or reset: level back to the clamped capacity, window empty
  task automatic reset_window();
    if (capacity_reg == '0) begin
      level = LevelW'(1);
    end else if (capacity_reg > LevelW'(MaxWindow)) begin
      level = LevelW'(MaxWindow);
    end else begin
      level = capacity_reg;
    end
    window_sum = '0;
    wr_pos     = '0;
    primed     = 1'b0;
  endtask

  task automatic fill_window(input logic signed [DataW-1:0] value);
    window_sum = '0;
    wr_pos     = '0;
    for (int i = 0; i < int'(level); i++) begin
      window_store[i] = value;
      window_sum      = window_sum + value;
    end
  endtask

  task automatic take_request();
    logic signed [DataW-1:0] stored;
    logic signed [SumW-1:0]  quotient;
    case (mode_i)
      MODE_SAMPLE: begin
        stored = narrow(sample_i);
        if (!primed) begin
          primed = 1'b1;
          fill_window(stored);
        end
        window_sum = window_sum - window_store[wr_pos[RingAw-1:0]] + stored;
        window_store[wr_pos[RingAw-1:0]] = stored;
        // signed divide truncates toward zero
        quotient = window_sum / $signed({1'b0, level});
        averages_due.push_back(quotient[DataW-1:0]);
        wr_pos = (wr_pos + LevelW'(1) >= level) ? '0 : wr_pos + LevelW'(1);
      end
      MODE_RESTART: begin
        primed = 1'b0;
      end
      MODE_LEVEL: begin
        // shrink only, and only once the window holds data
        if (primed && new_level_i != level && new_level_i != '0 && new_level_i <= level) begin
          level = new_level_i;
          fill_window(window_store[0]);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [DataW-1:0] want;
    if (!rst_ni) begin
      capacity_reg = LevelW'(MaxWindow);
      width_code   = SW_32;
      reset_window();
      averages_due.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CAPACITY) begin
          capacity_reg = cfg_wdata_i;
          reset_window();
        end else if (cfg_idx_i == REG_STORAGE) begin
          width_code = cfg_wdata_i[SwW-1:0];
          reset_window();
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_request();
      end
      if (out_valid_i && !out_stall_i) begin
        if (averages_due.size() == 0) begin
          $display("%0t: average %0d emitted with none outstanding", $time, average_i);
          mismatches++;
        end else begin
          want = averages_due.pop_front();
          if (average_i !== want) begin
            $display("%0t: average expected %0d, got %0d", $time, want, average_i);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= averages_due.size();
    end
  end

endmodule

FILE: test/tb_ring_moving_average.sv
// ----------------------------------------------------------------------------
// tb_ring_moving_average
// Drives requests and register writes into the moving-average block under
// random back-pressure; rma_checker predicts and compares every average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ring_moving_average;
  import rma_pkg::*;

  localparam int unsigned ClkPeriod       = 10;
  localparam int unsigned CycleLimit      = 1_000_000;
  // a change-level request keeps the block busy on a refill but yields no average
  localparam int unsigned SettleCycles    = MaxWindow + 16;
  localparam int unsigned ItemsPerSetting = 72;

  // mode code with no meaning: the block must swallow it
  localparam logic [ModeW-1:0] ModeIgnored = 2'd3;
  // storage code outside the list, behaves as 32 bits
  localparam logic [SwW-1:0]   SwAlias32   = 2'd3;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx   = REG_CAPACITY;
  logic [LevelW-1:0]       cfg_wdata = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic [ModeW-1:0]        mode      = MODE_SAMPLE;
  logic signed [DataW-1:0] sample    = '0;
  logic [LevelW-1:0]       new_level = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DataW-1:0] average;

  int unsigned gap_pct     = 0;   // chance per cycle that the sender holds off
  int unsigned stall_pct   = 0;   // chance per cycle that the receiver stalls
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending;

  always #(ClkPeriod / 2) clk = ~clk;

  ring_moving_average u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .sample_i    (sample),
    .new_level_i (new_level),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .average_o   (average)
  );

  rma_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .sample_i     (sample),
    .new_level_i  (new_level),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .average_i    (average),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver back-pressure, independent of valid
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL ring_moving_average");
      $finish;
    end
  end

  // One request. Valid stays high on return so that a back-to-back request
  // never lowers and raises it in the same step; gaps are inserted up front.
  task automatic send_request(input logic [ModeW-1:0]   m,
                              input logic [DataW-1:0]   s,
                              input logic [LevelW-1:0]  lvl);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    sample    <= s;
    new_level <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every average in flight has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // both registers, only with the block quiet
  task automatic configure(input logic [LevelW-1:0] cap, input logic [SwW-1:0] sw);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_idx   <= REG_STORAGE;
    cfg_wdata <= LevelW'(sw);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // extremes, small signed values near zero, and plenty of full-width noise
  function automatic logic [DataW-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return DataW'($urandom_range(200)) - DataW'(100);
      3:       return {{(DataW-16){1'b0}}, 16'h8000} ^ DataW'($urandom_range(255));
      default: return $urandom();
    endcase
  endfunction

  // mostly samples so the window actually turns over; restarts, shrinks and
  // junk modes mixed in. Level requests are usually in range, sometimes anything.
  task automatic random_request(input int unsigned level_hi);
    int unsigned      pick;
    logic [LevelW-1:0] lvl;
    pick = $urandom_range(99);
    if ($urandom_range(3) == 0) begin
      lvl = LevelW'($urandom_range(511));
    end else begin
      lvl = LevelW'($urandom_range(1, level_hi));
    end
    if (pick < 70) begin
      send_request(MODE_SAMPLE, pick_sample(), lvl);
    end else if (pick < 80) begin
      send_request(MODE_RESTART, $urandom(), lvl);
    end else if (pick < 94) begin
      send_request(MODE_LEVEL, $urandom(), lvl);
    end else begin
      send_request(ModeIgnored, $urandom(), lvl);
    end
  endtask

  task automatic run_setting(input logic [LevelW-1:0] cap, input logic [SwW-1:0] sw,
                             input int unsigned level_hi);
    configure(cap, sw);
    for (int i = 0; i < int'(ItemsPerSetting); i++) begin
      random_request(level_hi);
      // full drain mid-setting, plus the odd random one
      if (i == int'(ItemsPerSetting / 2) || $urandom_range(49) == 0) begin
        drain();
      end
    end
  endtask

  initial begin
    int unsigned cap;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    gap_pct   = 26;
    stall_pct = 83;

    // directed, at reset settings: level 256, 32-bit storage
    send_request(MODE_RESTART, '0, '0);            // restart with empty window
    send_request(MODE_LEVEL, '0, 9'd4);            // shrink before any sample
    send_request(MODE_SAMPLE, 32'h7FFF_FFFF, '0);  // first sample fills all 256
    send_request(MODE_SAMPLE, 32'h8000_0000, '0);
    send_request(MODE_SAMPLE, 32'hFFFF_FFFF, '0);
    send_request(MODE_LEVEL, '0, 9'd256);          // unchanged level
    send_request(MODE_LEVEL, '0, 9'd0);            // zero level
    send_request(MODE_LEVEL, '0, 9'd511);          // grow attempt
    send_request(MODE_LEVEL, '0, 9'd5);            // real shrink, refill from entry 0
    send_request(MODE_SAMPLE, -32'sd7, '0);
    send_request(MODE_SAMPLE, 32'sd3, '0);
    send_request(MODE_SAMPLE, 32'h8000_0000, '0);
    send_request(MODE_SAMPLE, 32'h7FFF_FFFF, '0);
    send_request(MODE_SAMPLE, 32'sd12, '0);
    send_request(MODE_SAMPLE, -32'sd1, '0);        // first write after the position wraps
    send_request(ModeIgnored, 32'hFFFF_FFFF, 9'h1FF);
    send_request(MODE_LEVEL, '0, 9'd1);
    send_request(MODE_SAMPLE, -32'sd100, '0);
    send_request(MODE_SAMPLE, 32'sd41, '0);
    send_request(MODE_RESTART, '0, '0);
    send_request(MODE_SAMPLE, 32'sd55, '0);        // refill after restart

    // random settings: clamped capacities, every storage code
    run_setting(9'd1, SW_8, 1);
    run_setting(9'd0, SW_16, 1);                   // capacity 0 acts as 1
    run_setting(9'd4, SwAlias32, 4);

    // roles swapped: sender sparse, receiver eager
    gap_pct   = 83;
    stall_pct = 26;
    run_setting(9'd511, SW_32, MaxWindow);         // clamps to the maximum
    run_setting(9'd256, SW_8, MaxWindow);
    cap = $urandom_range(2, 40);
    run_setting(LevelW'(cap), SW_16, cap);

    // flat out, no idling on either side
    gap_pct   = 0;
    stall_pct = 0;
    cap = $urandom_range(5, 64);
    run_setting(LevelW'(cap), SW_8, cap);
    run_setting(9'd17, SW_32, 17);

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS ring_moving_average");
    end else begin
      $display("FAIL ring_moving_average");
    end
    $finish;
  end

endmodule

FILE: ring_moving_average.f
hw/rtl/rma_pkg.sv
hw/rtl/rma_div.sv
hw/rtl/ring_moving_average.sv
hw/rtl/rma_checker.sv
test/rma_checker.sv
test/tb_ring_moving_average.sv
